FILE: rtl/vbb_pkg.sv
// vbb_pkg: shared constants and types of the vertical box blur unit
// no dependencies; compiled first

package vbb_pkg;

    // default sizes of the unit
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_RADIUS_DEFAULT = 8;
    localparam int PIXEL_BITS_DEFAULT = 16;

    // beat field widths
    localparam int PIX_FIELD_BITS = 16;

    // configuration registers
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 11;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 11;
    localparam int CFG_RADIUS_BITS = 4;

    localparam int IMAGE_WIDTH_RESET  = 1024;
    localparam int IMAGE_HEIGHT_RESET = 1024;
    localparam int BLUR_RADIUS_RESET  = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLUR_RADIUS  = 2'd2
    } cfg_index_t;

    // per pixel control that travels with the pixel into the accumulator
    typedef struct packed {
        logic emit;         // pixel produces a result beat
        logic last;         // last result beat of the frame
        logic sum_valid;    // column sum holds data of this frame
        logic store_valid;  // line store slot holds data of this frame
    } vbb_flags_t;

endpackage

FILE: rtl/vbb_stream_if.sv
// vbb_in_if / vbb_out_if: valid/ready pixel channels of the blur unit
// depends on vbb_pkg for the field widths

interface vbb_in_if;
    logic                               valid;
    logic                               ready;
    logic [vbb_pkg::PIX_FIELD_BITS-1:0] pixel_in;
    logic                               frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface vbb_out_if;
    logic                               valid;
    logic                               ready;
    logic [vbb_pkg::PIX_FIELD_BITS-1:0] pixel_out;
    logic                               frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

FILE: rtl/vbb_seq.sv
// vbb_seq: configuration registers, frame latch and raster position tracking
// decodes each input beat into column, line store slot and control flags; uses vbb_pkg

module vbb_seq #(
    parameter int MAX_WIDTH  = vbb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_RADIUS = vbb_pkg::MAX_RADIUS_DEFAULT,
    parameter int PIXEL_BITS = vbb_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [vbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vbb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               accept,
    input  logic [vbb_pkg::PIX_FIELD_BITS-1:0] pixel_in,
    input  logic                               frame_start,
    output logic                               item_live,
    output logic [$clog2(MAX_WIDTH)-1:0]       item_col,
    output logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] item_slot,
    output logic [PIXEL_BITS-1:0]              item_pixel,
    output logic [$clog2(MAX_RADIUS+1)-1:0]    item_radius,
    output vbb_pkg::vbb_flags_t                item_flags
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int PH_BITS   = $clog2(2 * MAX_RADIUS);
    localparam int ADDR_BITS = $clog2(2 * MAX_RADIUS * MAX_WIDTH);
    localparam int H_BITS    = vbb_pkg::CFG_HEIGHT_BITS;
    localparam int ROW_BITS  = $clog2(2**H_BITS + MAX_RADIUS);

    localparam int RESET_WIDTH  = (vbb_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                  MAX_WIDTH : vbb_pkg::IMAGE_WIDTH_RESET;
    localparam int RESET_RADIUS = (vbb_pkg::BLUR_RADIUS_RESET > MAX_RADIUS) ?
                                  MAX_RADIUS : vbb_pkg::BLUR_RADIUS_RESET;

    logic [vbb_pkg::CFG_WIDTH_BITS-1:0]  cfg_width_reg;
    logic [vbb_pkg::CFG_HEIGHT_BITS-1:0] cfg_height_reg;
    logic [vbb_pkg::CFG_RADIUS_BITS-1:0] cfg_radius_reg;

    logic [W_BITS-1:0]    use_width_reg;
    logic [H_BITS-1:0]    use_height_reg;
    logic [RAD_BITS-1:0]  use_radius_reg;

    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [ROW_BITS-1:0]  row_reg, row_next;
    logic [PH_BITS-1:0]   phase_reg, phase_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;

    logic [W_BITS-1:0]    sat_width, eff_width;
    logic [H_BITS-1:0]    sat_height, eff_height;
    logic [RAD_BITS-1:0]  sat_radius, eff_radius;

    logic [COL_BITS-1:0]  pos_col;
    logic [ROW_BITS-1:0]  pos_row;
    logic [PH_BITS-1:0]   pos_phase;
    logic [ADDR_BITS-1:0] pos_base;
    logic [ROW_BITS-1:0]  row_limit;
    logic                 col_end;
    logic                 phase_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= vbb_pkg::CFG_WIDTH_BITS'(vbb_pkg::IMAGE_WIDTH_RESET);
            cfg_height_reg <= vbb_pkg::CFG_HEIGHT_BITS'(vbb_pkg::IMAGE_HEIGHT_RESET);
            cfg_radius_reg <= vbb_pkg::CFG_RADIUS_BITS'(vbb_pkg::BLUR_RADIUS_RESET);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                vbb_pkg::CFG_IMAGE_WIDTH:
                    cfg_width_reg <= cfg_data[vbb_pkg::CFG_WIDTH_BITS-1:0];
                vbb_pkg::CFG_IMAGE_HEIGHT:
                    cfg_height_reg <= cfg_data[vbb_pkg::CFG_HEIGHT_BITS-1:0];
                vbb_pkg::CFG_BLUR_RADIUS:
                    cfg_radius_reg <= cfg_data[vbb_pkg::CFG_RADIUS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp registers into the supported range
    always_comb
    begin
        if (cfg_width_reg == '0)
            sat_width = W_BITS'(1);
        else if (32'(cfg_width_reg) > MAX_WIDTH)
            sat_width = W_BITS'(MAX_WIDTH);
        else
            sat_width = W_BITS'(cfg_width_reg);

        if (cfg_height_reg == '0)
            sat_height = H_BITS'(1);
        else
            sat_height = cfg_height_reg;

        if (32'(cfg_radius_reg) > MAX_RADIUS)
            sat_radius = RAD_BITS'(MAX_RADIUS);
        else
            sat_radius = RAD_BITS'(cfg_radius_reg);
    end

    // a frame start beat sees a fresh frame at row 0, column 0
    always_comb
    begin
        eff_width  = frame_start ? sat_width  : use_width_reg;
        eff_height = frame_start ? sat_height : use_height_reg;
        eff_radius = frame_start ? sat_radius : use_radius_reg;
        pos_col    = frame_start ? '0 : col_reg;
        pos_row    = frame_start ? '0 : row_reg;
        pos_phase  = frame_start ? '0 : phase_reg;
        pos_base   = frame_start ? '0 : base_reg;

        row_limit  = ROW_BITS'(eff_height) + ROW_BITS'(eff_radius);
        col_end    = (32'(pos_col) + 32'd1) >= 32'(eff_width);
        phase_end  = (32'(pos_phase) + 32'd1) >= (32'd2 * 32'(eff_radius));

        item_live   = pos_row < row_limit;
        item_col    = pos_col;
        item_slot   = pos_base + ADDR_BITS'(pos_col);
        item_radius = eff_radius;
        item_pixel  = (pos_row < ROW_BITS'(eff_height)) ? pixel_in[PIXEL_BITS-1:0] : '0;

        item_flags.emit        = pos_row >= ROW_BITS'(eff_radius);
        item_flags.last        = (pos_row == row_limit - ROW_BITS'(1)) && col_end;
        item_flags.sum_valid   = (pos_row != '0) && (eff_radius != '0);
        item_flags.store_valid = (eff_radius != '0) &&
                                 (32'(pos_row) >= (32'd2 * 32'(eff_radius)));

        if (col_end)
        begin
            col_next = '0;
            row_next = pos_row + ROW_BITS'(1);
            if (phase_end)
            begin
                phase_next = '0;
                base_next  = '0;
            end
            else
            begin
                phase_next = pos_phase + PH_BITS'(1);
                base_next  = pos_base + ADDR_BITS'(MAX_WIDTH);
            end
        end
        else
        begin
            col_next   = pos_col + COL_BITS'(1);
            row_next   = pos_row;
            phase_next = pos_phase;
            base_next  = pos_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_width_reg  <= W_BITS'(RESET_WIDTH);
            use_height_reg <= H_BITS'(vbb_pkg::IMAGE_HEIGHT_RESET);
            use_radius_reg <= RAD_BITS'(RESET_RADIUS);
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= '0;
            base_reg       <= '0;
        end
        else if (accept)
        begin
            if (frame_start)
            begin
                use_width_reg  <= sat_width;
                use_height_reg <= sat_height;
                use_radius_reg <= sat_radius;
            end
            // past the padding rows the position freezes until the next frame
            if (item_live)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                phase_reg <= phase_next;
                base_reg  <= base_next;
            end
        end
    end

endmodule

FILE: rtl/vbb_accum.sv
// vbb_accum: line store and running column sums with read-modify-write forwarding
// one pipeline stage after the registered memory reads; uses vbb_pkg

module vbb_accum #(
    parameter int MAX_WIDTH  = vbb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_RADIUS = vbb_pkg::MAX_RADIUS_DEFAULT,
    parameter int PIXEL_BITS = vbb_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic                                  in_live,
    input  logic [$clog2(MAX_WIDTH)-1:0]          in_col,
    input  logic [$clog2(2*MAX_RADIUS*MAX_WIDTH)-1:0] in_slot,
    input  logic [PIXEL_BITS-1:0]                 in_pixel,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]       in_radius,
    input  vbb_pkg::vbb_flags_t                   in_flags,
    output logic                                  in_free,
    output logic                                  div_valid,
    output logic [PIXEL_BITS+$clog2(2*MAX_RADIUS+2)-1:0] div_total,
    output logic [$clog2(MAX_RADIUS+1)-1:0]       div_radius,
    output logic                                  div_last,
    input  logic                                  div_free
);

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS  = $clog2(2 * MAX_RADIUS * MAX_WIDTH);
    localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int SUM_BITS   = PIXEL_BITS + $clog2(2 * MAX_RADIUS + 2);
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;

    logic [SUM_BITS-1:0]   sum_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] store_mem [STORE_DEPTH];

    logic                  s1_valid_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [ADDR_BITS-1:0]  s1_slot_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [RAD_BITS-1:0]   s1_radius_reg;
    vbb_pkg::vbb_flags_t   s1_flags_reg;

    logic [SUM_BITS-1:0]   sum_rd_reg;
    logic [PIXEL_BITS-1:0] store_rd_reg;
    logic                  fwd_sum_hit_reg;
    logic [SUM_BITS-1:0]   fwd_sum_reg;
    logic                  fwd_store_hit_reg;
    logic [PIXEL_BITS-1:0] fwd_store_reg;

    logic                  s1_fire;
    logic                  s1_write;
    logic [SUM_BITS-1:0]   sum_eff;
    logic [PIXEL_BITS-1:0] store_eff;
    logic [SUM_BITS-1:0]   total;
    logic [SUM_BITS-1:0]   new_sum;

    // non-emitting pixels leave the stage without waiting on the divider
    assign s1_fire  = s1_valid_reg && (!s1_flags_reg.emit || div_free);
    assign in_free  = !s1_valid_reg || s1_fire;
    assign s1_write = s1_fire && (s1_radius_reg != '0);

    always_comb
    begin
        if (!s1_flags_reg.sum_valid)
            sum_eff = '0;
        else if (fwd_sum_hit_reg)
            sum_eff = fwd_sum_reg;
        else
            sum_eff = sum_rd_reg;

        if (!s1_flags_reg.store_valid)
            store_eff = '0;
        else if (fwd_store_hit_reg)
            store_eff = fwd_store_reg;
        else
            store_eff = store_rd_reg;

        total   = sum_eff + SUM_BITS'(s1_pixel_reg);
        new_sum = total - SUM_BITS'(store_eff);
    end

    assign div_valid  = s1_valid_reg && s1_flags_reg.emit;
    assign div_total  = total;
    assign div_radius = s1_radius_reg;
    assign div_last   = s1_flags_reg.last;

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            sum_mem[s1_col_reg]    <= new_sum;
            store_mem[s1_slot_reg] <= s1_pixel_reg;
        end
    end

    // reads at accept miss a write of the same edge, so that one is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_rd_reg    <= sum_mem[in_col];
            store_rd_reg  <= store_mem[in_slot];
            fwd_sum_reg   <= new_sum;
            fwd_store_reg <= s1_pixel_reg;
            s1_col_reg    <= in_col;
            s1_slot_reg   <= in_slot;
            s1_pixel_reg  <= in_pixel;
            s1_radius_reg <= in_radius;
            s1_flags_reg  <= in_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            fwd_sum_hit_reg   <= 1'b0;
            fwd_store_hit_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                s1_valid_reg <= accept && in_live;
            if (accept)
            begin
                fwd_sum_hit_reg   <= s1_write && (s1_col_reg == in_col);
                fwd_store_hit_reg <= s1_write && (s1_slot_reg == in_slot);
            end
        end
    end

endmodule

FILE: rtl/vbb_divide.sv
// vbb_divide: division of the column total by 2*radius+1 through a reciprocal table
// two stages (table lookup, multiply into the output beat register); uses vbb_pkg, vbb_out_if

module vbb_divide #(
    parameter int MAX_RADIUS = vbb_pkg::MAX_RADIUS_DEFAULT,
    parameter int PIXEL_BITS = vbb_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [PIXEL_BITS+$clog2(2*MAX_RADIUS+2)-1:0] in_total,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]       in_radius,
    input  logic                                  in_last,
    output logic                                  in_free,
    vbb_out_if.source                             out_stream
);

    localparam int DIV_BITS  = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUM_BITS  = PIXEL_BITS + DIV_BITS;
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int SHIFT     = SUM_BITS + DIV_BITS;
    localparam int M_BITS    = SHIFT + 1;
    localparam int PROD_BITS = SUM_BITS + M_BITS;
    localparam int TBL_DEPTH = 2**RAD_BITS;

    logic [M_BITS-1:0] recip_tbl [TBL_DEPTH];

    // ceil(2^SHIFT / (2r+1)) is exact for every total below 2^SUM_BITS;
    // radius zero uses 2^SHIFT so the pixel passes unchanged
    for (genvar i = 0; i < TBL_DEPTH; i++)
    begin : g_recip
        localparam logic [63:0] DIVISOR = 64'(2 * i + 1);
        localparam logic [63:0] RECIP   = (i == 0) ? (64'd1 << SHIFT) :
                                          (i <= MAX_RADIUS) ?
                                          (((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR) :
                                          64'd0;
        assign recip_tbl[i] = M_BITS'(RECIP);
    end

    logic                  s2_valid_reg;
    logic [SUM_BITS-1:0]   s2_total_reg;
    logic [M_BITS-1:0]     s2_recip_reg;
    logic                  s2_last_reg;

    logic                  out_valid_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  out_last_reg;

    logic                  s3_free;

    assign s3_free = !out_valid_reg || out_stream.ready;
    assign in_free = !s2_valid_reg || s3_free;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_free)
        begin
            s2_total_reg <= in_total;
            s2_recip_reg <= recip_tbl[in_radius];
            s2_last_reg  <= in_last;
        end
        if (s2_valid_reg && s3_free)
        begin
            prod_reg     <= PROD_BITS'(s2_total_reg) * PROD_BITS'(s2_recip_reg);
            out_last_reg <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                s2_valid_reg <= in_valid;
            if (s3_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_stream.valid     = out_valid_reg;
    assign out_stream.pixel_out = vbb_pkg::PIX_FIELD_BITS'(prod_reg[SHIFT +: PIXEL_BITS]);
    assign out_stream.frame_end = out_last_reg;

endmodule

FILE: rtl/vertical_box_blur_unit.sv
// vertical box blur: a beat passes the accum stage, divide lookup stage and output register;
// its result is for the pixel radius rows above the triggering one; throughput 1 beat/cycle
// unless output stalls, held by column sum read-modify-write forwarding from the write stage.
// reset: asynchronous, active low; registers return to width 1024, height 1024, radius 1 and a
// frame begins at reset; line store and sums need no clearing pass, the row count masks them.
// depends on vbb_pkg, vbb_stream_if, vbb_seq, vbb_accum, vbb_divide

module vertical_box_blur_unit #(
    parameter int MAX_WIDTH  = vbb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_RADIUS = vbb_pkg::MAX_RADIUS_DEFAULT,
    parameter int PIXEL_BITS = vbb_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [vbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vbb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    vbb_in_if.sink                             in_stream,
    vbb_out_if.source                          out_stream
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS = $clog2(2 * MAX_RADIUS * MAX_WIDTH);
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int SUM_BITS  = PIXEL_BITS + $clog2(2 * MAX_RADIUS + 2);

    logic                  accept;
    logic                  acc_free;
    logic                  item_live;
    logic [COL_BITS-1:0]   item_col;
    logic [ADDR_BITS-1:0]  item_slot;
    logic [PIXEL_BITS-1:0] item_pixel;
    logic [RAD_BITS-1:0]   item_radius;
    vbb_pkg::vbb_flags_t   item_flags;

    logic                  div_valid;
    logic [SUM_BITS-1:0]   div_total;
    logic [RAD_BITS-1:0]   div_radius;
    logic                  div_last;
    logic                  div_free;

    assign in_stream.ready = acc_free;
    assign accept          = in_stream.valid && acc_free;

    vbb_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .pixel_in     (in_stream.pixel_in),
        .frame_start  (in_stream.frame_start),
        .item_live    (item_live),
        .item_col     (item_col),
        .item_slot    (item_slot),
        .item_pixel   (item_pixel),
        .item_radius  (item_radius),
        .item_flags   (item_flags)
    );

    vbb_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_live    (item_live),
        .in_col     (item_col),
        .in_slot    (item_slot),
        .in_pixel   (item_pixel),
        .in_radius  (item_radius),
        .in_flags   (item_flags),
        .in_free    (acc_free),
        .div_valid  (div_valid),
        .div_total  (div_total),
        .div_radius (div_radius),
        .div_last   (div_last),
        .div_free   (div_free)
    );

    vbb_divide #(
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_total   (div_total),
        .in_radius  (div_radius),
        .in_last    (div_last),
        .in_free    (div_free),
        .out_stream (out_stream)
    );

endmodule
